// ----- src/pvb_pkg.sv -----
`timescale 1ns / 1ps

package pvb_pkg;

  localparam int MAX_VOICES      = 15;
  localparam int SAMPLE_RATE     = 48000;
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;

  localparam int NOTE_W   = 7;
  localparam int NOTES    = 1 << NOTE_W;
  localparam int OFFS_W   = 16;
  localparam int MIX_W    = 20;
  localparam int VCNT_W   = 4;
  localparam int SMP_W    = 16;
  localparam int MAG_W    = 15;
  localparam int SINE_AMP = 32767;

  localparam int CNT_W   = $clog2(MAX_VOICES + 1);
  localparam int VIDX_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int QW      = SINE_TABLE_BITS - 2;
  localparam int QUARTER = 1 << QW;

  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam longint unsigned SEMITONE_Q16 [12] = '{
    64'd65536, 64'd69433, 64'd73562, 64'd77936, 64'd82570, 64'd87480,
    64'd92682, 64'd98193, 64'd104032, 64'd110218, 64'd116772, 64'd123715
  };

  typedef enum logic [1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_TICK     = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic start;
    logic issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic more;
    logic busy;
    logic out_full;
  } sts_t;

  typedef logic [PHASE_BITS-1:0] inc_table_t [NOTES];
  typedef logic [MAG_W-1:0] qsine_table_t [QUARTER];

  function automatic inc_table_t build_inc_table();
    inc_table_t tbl;
    longint unsigned f;
    longint unsigned q;
    longint unsigned rem;
    int e;
    int s;
    for (int n = 0; n < NOTES; n++) begin
      e = n / 12;
      s = n % 12;
      f = (64'd110 * SEMITONE_Q16[s]) << e;
      q = f / SAMPLE_RATE;
      rem = f % SAMPLE_RATE;
      for (int k = 0; k < PHASE_BITS - 16; k++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= SAMPLE_RATE) begin
          rem = rem - SAMPLE_RATE;
          q = q | 64'd1;
        end
      end
      tbl[n] = PHASE_BITS'(q);
    end
    return tbl;
  endfunction

  function automatic longint unsigned quarter_sine(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    x  = (r * HALF_PI_Q30) / QUARTER;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    v  = (((x * t) >> 30) * SINE_AMP + (ONE_Q30 >> 1)) >> 30;
    if (v > SINE_AMP) begin
      v = SINE_AMP;
    end
    return v;
  endfunction

  function automatic qsine_table_t build_qsine();
    qsine_table_t tbl;
    for (int r = 0; r < QUARTER; r++) begin
      tbl[r] = MAG_W'(quarter_sine(longint'(r)));
    end
    return tbl;
  endfunction

  localparam inc_table_t   INC_TABLE = build_inc_table();
  localparam qsine_table_t QSINE     = build_qsine();
  localparam logic [MAG_W-1:0] QSINE_PEAK = MAG_W'(quarter_sine(longint'(QUARTER)));

endpackage

// ----- src/pvb_ctrl.sv -----
`timescale 1ns / 1ps

module pvb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic [1:0]    action_i,
  output logic          s_ready_o,
  input  logic          m_ready_i,
  input  pvb_pkg::sts_t sts_i,
  output pvb_pkg::cmd_t cmd_o
);

  pvb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pvb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      pvb_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          unique case (pvb_pkg::action_e'(action_i))
            pvb_pkg::ACT_NOTE_ON:  cmd_o.push = !sts_i.full;
            pvb_pkg::ACT_NOTE_OFF: cmd_o.pop  = !sts_i.empty;
            pvb_pkg::ACT_TICK: begin
              cmd_o.start = 1'b1;
              state_d     = pvb_pkg::ST_RUN;
            end
            default: ;
          endcase
        end
      end
      pvb_pkg::ST_RUN: begin
        if (sts_i.more) begin
          cmd_o.issue = 1'b1;
        end else begin
          state_d = pvb_pkg::ST_FINISH;
        end
      end
      pvb_pkg::ST_FINISH: begin
        if (!sts_i.busy && (!sts_i.out_full || m_ready_i)) begin
          cmd_o.load_out = 1'b1;
          state_d        = pvb_pkg::ST_IDLE;
        end
      end
      default: state_d = pvb_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pvb_pkg::ST_RUN) && !sts_i.more |=> state_q == pvb_pkg::ST_FINISH)
    else $error("run did not move to finish");

  a_idle_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> state_q == pvb_pkg::ST_IDLE)
    else $error("no return to idle after result load");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == pvb_pkg::ST_RUN)
    else $error("tick did not start a voice pass");
`endif

endmodule

// ----- src/pvb_datapath.sv -----
`timescale 1ns / 1ps

module pvb_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pvb_pkg::cmd_t               cmd_i,
  output pvb_pkg::sts_t               sts_o,
  input  logic [pvb_pkg::NOTE_W-1:0]  note_i,
  input  logic                        cfg_we_i,
  input  logic [pvb_pkg::OFFS_W-1:0]  cfg_wdata_i,
  input  logic                        m_ready_i,
  output logic                        m_valid_o,
  output logic [pvb_pkg::MIX_W-1:0]   m_sample_o,
  output logic [pvb_pkg::VCNT_W-1:0]  m_count_o
);

  localparam int CW = pvb_pkg::CNT_W;
  localparam int VW = pvb_pkg::VIDX_W;
  localparam int PB = pvb_pkg::PHASE_BITS;
  localparam int QW = pvb_pkg::QW;

  logic [pvb_pkg::NOTE_W-1:0] note_q  [pvb_pkg::MAX_VOICES];
  logic [PB-1:0]              phase_q [pvb_pkg::MAX_VOICES];

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [pvb_pkg::OFFS_W-1:0] offset_q;

  logic          s1_valid_q;
  logic [1:0]    s1_quad_q;
  logic [QW-1:0] s1_r_q;
  logic                             s2_valid_q;
  logic signed [pvb_pkg::SMP_W-1:0] s2_sine_q, sine;
  logic [pvb_pkg::MIX_W-1:0] acc_q, acc_d;

  logic                        out_valid_q, out_valid_d;
  logic [pvb_pkg::MIX_W-1:0]   out_sample_q;
  logic [pvb_pkg::VCNT_W-1:0]  out_count_q;

  logic [VW-1:0]                  vidx;
  logic [VW-1:0]                  push_idx;
  logic [PB-1:0]                  cur_phase;
  logic [pvb_pkg::NOTE_W-1:0]     cur_note;
  logic [pvb_pkg::OFFS_W-1:0]     sum_hi;
  logic [pvb_pkg::SINE_TABLE_BITS-1:0] sidx;
  logic [pvb_pkg::MAG_W-1:0]      mag;

  assign vidx      = idx_q[VW-1:0];
  assign push_idx  = count_q[VW-1:0];
  assign cur_phase = phase_q[vidx];
  assign cur_note  = note_q[vidx];
  assign sum_hi    = cur_phase[PB-1 -: pvb_pkg::OFFS_W] + offset_q;
  assign sidx      = sum_hi[pvb_pkg::OFFS_W-1 -: pvb_pkg::SINE_TABLE_BITS];

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
    end
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (cmd_i.issue) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // quadrant fold of the quarter-wave table
  always_comb begin
    if (s1_quad_q[0]) begin
      if (s1_r_q == '0) begin
        mag = pvb_pkg::QSINE_PEAK;
      end else begin
        mag = pvb_pkg::QSINE[QW'(pvb_pkg::QUARTER - int'(s1_r_q))];
      end
    end else begin
      mag = pvb_pkg::QSINE[s1_r_q];
    end
    if (s1_quad_q[1]) begin
      sine = -$signed({1'b0, mag});
    end else begin
      sine = $signed({1'b0, mag});
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.start) begin
      acc_d = '0;
    end else if (s2_valid_q) begin
      acc_d = acc_q + pvb_pkg::MIX_W'(s2_sine_q);
    end
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      offset_q    <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      s1_valid_q  <= cmd_i.issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    s1_quad_q <= sidx[pvb_pkg::SINE_TABLE_BITS-1 -: 2];
    s1_r_q    <= sidx[QW-1:0];
    s2_sine_q <= sine;
    if (cmd_i.push) begin
      note_q[push_idx]  <= note_i;
      phase_q[push_idx] <= '0;
    end
    if (cmd_i.issue) begin
      phase_q[vidx] <= cur_phase + pvb_pkg::INC_TABLE[cur_note];
    end
    if (cmd_i.load_out) begin
      out_sample_q <= acc_q;
      out_count_q  <= pvb_pkg::VCNT_W'(count_q);
    end
  end

  assign sts_o.full     = (count_q == CW'(pvb_pkg::MAX_VOICES));
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.more     = (idx_q < count_q);
  assign sts_o.busy     = s1_valid_q || s2_valid_q;
  assign sts_o.out_full = out_valid_q;

  assign m_valid_o  = out_valid_q;
  assign m_sample_o = out_sample_q;
  assign m_count_o  = out_count_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(pvb_pkg::MAX_VOICES))
    else $error("voice count above stack depth");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not raise voice count");

  a_issue_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |=> s1_valid_q && $stable(count_q))
    else $error("voice count changed during tick");

  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !s1_valid_q && !s2_valid_q && !cmd_i.issue)
    else $error("result loaded before pipeline drained");
`endif

endmodule

// ----- src/polyphonic_sine_voice_bank.sv -----
`timescale 1ns / 1ps

// Polyphonic sine voice bank.
// Input stream: tuser carries the action (note on, note off, tick), tdata
// carries the note number. Output stream: one request per tick with the
// mixed sample and the voice count. Note on and note off give no output.
// Note on pushes a voice at phase zero (ignored when the stack is full);
// note off pops the newest voice (ignored when empty).
// A tick walks the voice stack one voice per cycle through the shared
// phase-add and sine-lookup datapath, then drains its two pipeline stages
// before the sum is loaded into the output register; no new request is
// accepted until then.
// The finished result sits in an output register; new notes are accepted
// while it waits. A following tick runs its voice pass but holds its sum
// until the receiver takes the pending result.
// cfg_we_i writes the 16-bit phase offset; write only while idle.
// Reset empties the voice stack, clears the offset and drops any pending
// output; voice slots themselves are not cleared.

module polyphonic_sine_voice_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] note, [7] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [19:0] mixed_sample, [23:20] voices_active
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  pvb_pkg::cmd_t cmd;
  pvb_pkg::sts_t sts;

  logic [pvb_pkg::MIX_W-1:0]  m_sample;
  logic [pvb_pkg::VCNT_W-1:0] m_count;

  pvb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .action_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pvb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .note_i      (s_axis_tdata[pvb_pkg::NOTE_W-1:0]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_sample_o  (m_sample),
    .m_count_o   (m_count)
  );

  assign m_axis_tdata = {m_count, m_sample};

endmodule

// ----- tb/voice_bank_checker.sv -----
`timescale 1ns / 1ps

module voice_bank_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [7:0]  req_data_i,
  input  logic [1:0]  req_user_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [23:0] res_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          pending_o,
  output int          errors_o
);

  localparam longint unsigned Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI = 64'd1686629713;
  localparam longint unsigned AMP     = 64'd32767;

  typedef struct packed {
    logic signed [pvb_pkg::MIX_W-1:0] mix;
    logic [pvb_pkg::VCNT_W-1:0]       voices;
  } tick_result_t;

  tick_result_t                   expected_ticks [$];
  logic [pvb_pkg::OFFS_W-1:0]     offset;
  int unsigned                    voice_cnt;
  logic [pvb_pkg::NOTE_W-1:0]     voice_note  [pvb_pkg::MAX_VOICES];
  logic [pvb_pkg::PHASE_BITS-1:0] voice_phase [pvb_pkg::MAX_VOICES];
  int                             mismatches = 0;

  // 2^(s/12) in Q16
  function automatic longint unsigned semitone_ratio(int s);
    case (s)
      0:       return 64'd65536;
      1:       return 64'd69433;
      2:       return 64'd73562;
      3:       return 64'd77936;
      4:       return 64'd82570;
      5:       return 64'd87480;
      6:       return 64'd92682;
      7:       return 64'd98193;
      8:       return 64'd104032;
      9:       return 64'd110218;
      10:      return 64'd116772;
      default: return 64'd123715;
    endcase
  endfunction

  function automatic logic [pvb_pkg::PHASE_BITS-1:0] phase_step(
    logic [pvb_pkg::NOTE_W-1:0] n
  );
    longint unsigned hz_q16;
    hz_q16 = (64'd110 * semitone_ratio(int'(n) % 12)) << (int'(n) / 12);
    return pvb_pkg::PHASE_BITS'((hz_q16 << (pvb_pkg::PHASE_BITS - 16)) /
                                64'(pvb_pkg::SAMPLE_RATE));
  endfunction

  function automatic longint unsigned quarter_wave(longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    x  = (r * HALF_PI) / 64'(pvb_pkg::QUARTER);
    x2 = (x * x) >> 30;
    t  = Q30 - x2 / 110;
    t  = Q30 - ((x2 * t) >> 30) / 72;
    t  = Q30 - ((x2 * t) >> 30) / 42;
    t  = Q30 - ((x2 * t) >> 30) / 20;
    t  = Q30 - ((x2 * t) >> 30) / 6;
    v  = (((x * t) >> 30) * AMP + (Q30 >> 1)) >> 30;
    return (v > AMP) ? AMP : v;
  endfunction

  function automatic int sine_at(logic [pvb_pkg::PHASE_BITS-1:0] ph);
    logic [pvb_pkg::SINE_TABLE_BITS-1:0] idx;
    logic [1:0]                          quad;
    longint unsigned                     r;
    longint unsigned                     v;
    idx  = ph[pvb_pkg::PHASE_BITS-1 -: pvb_pkg::SINE_TABLE_BITS];
    quad = idx[pvb_pkg::SINE_TABLE_BITS-1 -: 2];
    r    = 64'(idx[pvb_pkg::QW-1:0]);
    v    = quad[0] ? quarter_wave(64'(pvb_pkg::QUARTER) - r) : quarter_wave(r);
    return quad[1] ? -int'(v) : int'(v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    int           sum;
    if (!rst_ni) begin
      voice_cnt = 0;
      offset    = '0;
      expected_ticks.delete();
      pending_o <= 0;
      errors_o  <= mismatches;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected sample, expected none, got %h", $time, res_data_i);
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          if (res_data_i[pvb_pkg::MIX_W-1:0] !== want.mix) begin
            $display("%0t: mixed_sample expected %0d got %0d", $time, want.mix,
                     $signed(res_data_i[pvb_pkg::MIX_W-1:0]));
            mismatches++;
          end
          if (res_data_i[pvb_pkg::MIX_W +: pvb_pkg::VCNT_W] !== want.voices) begin
            $display("%0t: voices_active expected %0d got %0d", $time, want.voices,
                     res_data_i[pvb_pkg::MIX_W +: pvb_pkg::VCNT_W]);
            mismatches++;
          end
        end
      end

      if (cfg_we_i) begin
        offset = cfg_wdata_i;
      end

      if (req_valid_i && req_ready_i) begin
        case (pvb_pkg::action_e'(req_user_i))
          pvb_pkg::ACT_NOTE_ON: begin
            if (voice_cnt < pvb_pkg::MAX_VOICES) begin
              voice_note[voice_cnt]  = req_data_i[pvb_pkg::NOTE_W-1:0];
              voice_phase[voice_cnt] = '0;
              voice_cnt++;
            end
          end
          pvb_pkg::ACT_NOTE_OFF: begin
            if (voice_cnt > 0) begin
              voice_cnt--;
            end
          end
          pvb_pkg::ACT_TICK: begin
            sum = 0;
            for (int i = 0; i < voice_cnt; i++) begin
              sum += sine_at(voice_phase[i] + (pvb_pkg::PHASE_BITS'(offset) <<
                                               (pvb_pkg::PHASE_BITS - pvb_pkg::OFFS_W)));
              voice_phase[i] = voice_phase[i] + phase_step(voice_note[i]);
            end
            want.mix    = pvb_pkg::MIX_W'(sum);
            want.voices = pvb_pkg::VCNT_W'(voice_cnt);
            expected_ticks = {expected_ticks, want};
          end
          default: begin
          end
        endcase
      end

      pending_o <= expected_ticks.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] ACT_UNUSED = 2'b11;
  localparam int RX_HOLD    = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 24;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [15:0] cfg_wdata_i   = '0;

  int pending;
  int errors;
  int tx_wait_max = 7;
  int rx_wait_max = 7;
  bit rx_hold_req = 1'b0;
  int idle_cycles = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  polyphonic_sine_voice_bank dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  voice_bank_checker u_voice_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_user_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // sample sink
  initial begin
    int gap;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
      end
      gap = $urandom_range(0, rx_wait_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send(input logic [1:0] act, input logic [pvb_pkg::NOTE_W-1:0] nt);
    int gap;
    gap = $urandom_range(0, tx_wait_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, nt};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // let all ticks drain, then give the offset a new value
  task automatic set_offset(input logic [pvb_pkg::OFFS_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // empty the stack, fill it with 15 fresh voices and sample at phase zero
  task automatic full_chord();
    repeat (pvb_pkg::MAX_VOICES) send(pvb_pkg::ACT_NOTE_OFF, pvb_pkg::NOTE_W'($urandom));
    repeat (pvb_pkg::MAX_VOICES) send(pvb_pkg::ACT_NOTE_ON, pvb_pkg::NOTE_W'($urandom));
    send(pvb_pkg::ACT_TICK, pvb_pkg::NOTE_W'($urandom));
  endtask

  task automatic random_notes(input int count, input int on_pct, input int off_pct);
    int pick;
    logic [1:0] act;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < on_pct) begin
        act = pvb_pkg::ACT_NOTE_ON;
      end else if (pick < on_pct + off_pct) begin
        act = pvb_pkg::ACT_NOTE_OFF;
      end else if (pick < on_pct + off_pct + 3) begin
        act = ACT_UNUSED;
      end else begin
        act = pvb_pkg::ACT_TICK;
      end
      send(act, pvb_pkg::NOTE_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_offset(16'h0000);
    send(pvb_pkg::ACT_TICK, 7'd0);
    send(pvb_pkg::ACT_NOTE_OFF, 7'd0);
    send(ACT_UNUSED, 7'd127);
    send(pvb_pkg::ACT_NOTE_ON, 7'd0);
    send(pvb_pkg::ACT_TICK, 7'd127);
    send(pvb_pkg::ACT_NOTE_ON, 7'd127);
    send(pvb_pkg::ACT_TICK, 7'd0);
    send(pvb_pkg::ACT_TICK, 7'd0);
    send(pvb_pkg::ACT_NOTE_OFF, 7'd127);
    send(pvb_pkg::ACT_TICK, 7'd0);
    for (int i = 0; i < pvb_pkg::MAX_VOICES - 1; i++) begin
      send(pvb_pkg::ACT_NOTE_ON, pvb_pkg::NOTE_W'(i * 9 + 5));
    end
    send(pvb_pkg::ACT_NOTE_ON, 7'd64);   // stack full, dropped
    send(pvb_pkg::ACT_TICK, 7'd0);
    send(pvb_pkg::ACT_TICK, 7'd0);

    set_offset(16'hFFFF);
    random_notes(60, 25, 8);

    tx_wait_max = 0;
    rx_wait_max = 0;
    set_offset(16'($urandom));
    random_notes(60, 8, 25);

    // receiver stalls while the sender keeps pushing
    set_offset(16'hC000);
    full_chord();
    rx_hold_req = 1'b1;
    random_notes(50, 15, 5);

    tx_wait_max = 7;
    rx_wait_max = 7;
    set_offset(16'($urandom));
    random_notes(80, 20, 20);

    rx_wait_max = 0;
    set_offset(16'h4000);
    full_chord();
    random_notes(60, 20, 10);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
